[design/bpc_pkg.sv]
// bpc_pkg: types, tables and constants of the position commutator.
// No dependencies; used by bldc_position_commutator.
package bpc_pkg;

   localparam int unsigned HALL_W    = 3;
   localparam int unsigned EDGES_W   = 8;
   localparam int unsigned PATTERN_W = 6;
   localparam int unsigned DUTY_W    = 11;
   localparam int unsigned POS_W     = 20;
   localparam int unsigned EDGE_W    = 16;
   localparam int unsigned PASS_W    = 14;
   localparam int unsigned CSR_W     = 20;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [POS_W-1:0]  POS_MAX  = 20'hF_FFFF;
   localparam logic [EDGE_W-1:0] EDGE_MAX = 16'hFFFF;
   localparam logic [PASS_W-1:0] PASS_MAX = 14'h3FFF;

   localparam logic [DUTY_W-1:0] DUTY_NEG   = 11'd102;
   localparam logic [DUTY_W-1:0] DUTY_CAP   = 11'd819;
   localparam logic [DUTY_W-1:0] DUTY_FORCE = 11'd768;
   localparam logic [DUTY_W-1:0] DUTY_FULL  = 11'd1024;

   // reset values of the control registers
   localparam logic [19:0] TARGET_RST = 20'd3510;
   localparam logic [2:0]  ORIGIN_RST = 3'd0;
   localparam logic [2:0]  HOME_RST   = 3'd0;
   localparam logic [2:0]  LEAD_RST   = 3'b110;   // -2
   localparam logic [15:0] PGAIN_RST  = 16'd438;
   localparam logic [19:0] DGAIN_RST  = 20'd393846;

   // six-step drive entries, entries 6 and 7 all off
   localparam logic [PATTERN_W-1:0] PHASE_TABLE [8] = '{
      6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
   };

   // raw hall pattern to rotor state, invalid patterns give 7
   localparam logic [2:0] ROTOR_MAP [8] = '{
      3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET_COUNT = 3'd0,
      CSR_ROTOR_ORIGIN = 3'd1,
      CSR_HOME_HALL    = 3'd2,
      CSR_PHASE_LEAD   = 3'd3,
      CSR_P_GAIN       = 3'd4,
      CSR_D_GAIN       = 3'd5
   } csr_addr_type;

   typedef struct packed {
      logic [HALL_W-1:0]  hall;
      logic [EDGES_W-1:0] encoder_edges;
      logic               speed_sample;
   } req_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] drive_pattern;
      logic [DUTY_W-1:0]    duty;
      logic [POS_W-1:0]     position;
      logic                 below_target;
      logic                 commutated;
   } rsp_type;

endpackage

[design/bldc_position_commutator.sv]
// rsp_valid rises once a req transfer has passed the stage 1, stage 2 and output registers;
// one transfer per cycle sustained while rsp_stall stays low.
// Three stages: position/state update, gain products, duty clamp and commutation.
// Throughput is set by the per-tick state loop (edge count, pass count), closed in stage 1.
// Synchronous active-high reset: empty pipeline, counters zero, drive 0x12, duty 1024,
// control registers back to their defaults. Depends on bpc_pkg.
module bldc_position_commutator #(
   parameter int unsigned COUNTS_PER_REV = 117
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bpc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bpc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bpc_pkg::CSR_W-1:0]     csr_wdata
);

   // base = pass_count * COUNTS_PER_REV, kept incrementally
   localparam int unsigned BASE_MAX = int'(bpc_pkg::PASS_MAX) * COUNTS_PER_REV;
   localparam int unsigned BASE_W   = $clog2(BASE_MAX + 1);
   localparam int unsigned SUM_W    = ((BASE_W > bpc_pkg::POS_W) ? BASE_W : bpc_pkg::POS_W) + 1;
   localparam int unsigned ERR_W    = bpc_pkg::POS_W + 1;
   localparam int unsigned PP_W     = 17 + ERR_W;
   localparam int unsigned PD_W     = 21 + ERR_W;
   localparam int unsigned DEM_W    = PD_W;

   // ---------------- control registers ----------------
   logic [19:0]        target_ff;
   logic [2:0]         origin_ff;
   logic [2:0]         home_ff;
   logic signed [2:0]  lead_ff;
   logic [15:0]        p_gain_ff;
   logic [19:0]        d_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= bpc_pkg::TARGET_RST;
         origin_ff <= bpc_pkg::ORIGIN_RST;
         home_ff   <= bpc_pkg::HOME_RST;
         lead_ff   <= bpc_pkg::LEAD_RST;
         p_gain_ff <= bpc_pkg::PGAIN_RST;
         d_gain_ff <= bpc_pkg::DGAIN_RST;
      end else if (csr_we) begin
         case (bpc_pkg::csr_addr_type'(csr_addr))
            bpc_pkg::CSR_TARGET_COUNT: target_ff <= csr_wdata[19:0];
            bpc_pkg::CSR_ROTOR_ORIGIN: origin_ff <= csr_wdata[2:0];
            bpc_pkg::CSR_HOME_HALL:    home_ff   <= csr_wdata[2:0];
            bpc_pkg::CSR_PHASE_LEAD:   lead_ff   <= csr_wdata[2:0];
            bpc_pkg::CSR_P_GAIN:       p_gain_ff <= csr_wdata[15:0];
            bpc_pkg::CSR_D_GAIN:       d_gain_ff <= csr_wdata[19:0];
            default: ;   // writes beyond the map are dropped
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   // A stage advances when it is empty or its successor advances, so a rsp stall
   // backs up one stage at a time; the front keeps taking transfers until all
   // three stages hold one.
   logic s1_vld_ff, s2_vld_ff, out_vld_ff;
   logic adv1, adv2, adv3, req_fire;

   assign adv3      = !out_vld_ff || !rsp_stall;
   assign adv2      = !s2_vld_ff  || adv3;
   assign adv1      = !s1_vld_ff  || adv2;
   assign req_stall = !adv1;
   assign req_fire  = req_valid && adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv1) s1_vld_ff  <= req_valid;
         if (adv2) s2_vld_ff  <= s1_vld_ff;
         if (adv3) out_vld_ff <= s2_vld_ff;
      end
   end

   // ---------------- stage 1: tick state and position ----------------
   logic [bpc_pkg::EDGE_W-1:0]  edge_count_ff, edge_count_in;
   logic [bpc_pkg::PASS_W-1:0]  pass_count_ff, pass_count_in;
   logic [BASE_W-1:0]           base_ff, base_in;
   logic [2:0]                  last_rotor_ff, last_rotor_in;
   logic [bpc_pkg::POS_W-1:0]   sampled_ff, sampled_in;
   logic signed [ERR_W-1:0]     speed_delta_ff, speed_delta_in;

   logic [bpc_pkg::EDGE_W:0]    edge_sum;
   logic [bpc_pkg::EDGE_W-1:0]  edge_sat;
   logic [SUM_W-1:0]            pos_sum;
   logic [bpc_pkg::POS_W-1:0]   pos;
   logic                        below;
   logic signed [ERR_W-1:0]     err;
   logic [2:0]                  rotor;
   logic                        changed, pass_evt;
   logic [5:0]                  lead_x;
   logic [2:0]                  drive_idx;

   always_comb begin
      edge_sum = {1'b0, edge_count_ff} + (bpc_pkg::EDGE_W + 1)'(req_data.encoder_edges);
      edge_sat = edge_sum[bpc_pkg::EDGE_W] ? bpc_pkg::EDGE_MAX : edge_sum[bpc_pkg::EDGE_W-1:0];

      // position from the pass count before this tick's pass update
      pos_sum = SUM_W'(base_ff) + SUM_W'(edge_sat);
      pos     = (pos_sum > SUM_W'(bpc_pkg::POS_MAX)) ? bpc_pkg::POS_MAX
                                                    : pos_sum[bpc_pkg::POS_W-1:0];
      below   = target_ff > pos;
      err     = $signed({1'b0, target_ff}) - $signed({1'b0, pos});

      rotor    = bpc_pkg::ROTOR_MAP[req_data.hall];
      changed  = rotor != last_rotor_ff;
      pass_evt = changed && (req_data.hall == home_ff);

      // rotor - origin + lead + 6, remainder by 6 truncated toward zero;
      // a negative remainder keeps its low bits (-1 lands on the all-off entry)
      lead_x = 6'(rotor) - 6'(origin_ff) + 6'(lead_ff) + 6'd6;
      if (lead_x[5])
         drive_idx = lead_x[2:0];
      else if (lead_x >= 6'd12)
         drive_idx = 3'(lead_x - 6'd12);
      else if (lead_x >= 6'd6)
         drive_idx = 3'(lead_x - 6'd6);
      else
         drive_idx = lead_x[2:0];

      edge_count_in  = pass_evt ? '0 : edge_sat;
      pass_count_in  = pass_count_ff;
      base_in        = base_ff;
      if (pass_evt && (pass_count_ff < bpc_pkg::PASS_MAX)) begin
         pass_count_in = pass_count_ff + 1'b1;
         base_in       = base_ff + BASE_W'(COUNTS_PER_REV);
      end
      last_rotor_in  = rotor;
      sampled_in     = sampled_ff;
      speed_delta_in = speed_delta_ff;
      if (req_data.speed_sample) begin
         speed_delta_in = $signed({1'b0, pos}) - $signed({1'b0, sampled_ff});
         sampled_in     = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff  <= '0;
         pass_count_ff  <= '0;
         base_ff        <= '0;
         last_rotor_ff  <= '0;
         sampled_ff     <= '0;
         speed_delta_ff <= '0;
      end else if (req_fire) begin
         edge_count_ff  <= edge_count_in;
         pass_count_ff  <= pass_count_in;
         base_ff        <= base_in;
         last_rotor_ff  <= last_rotor_in;
         sampled_ff     <= sampled_in;
         speed_delta_ff <= speed_delta_in;
      end
   end

   // stage 1 payload
   logic signed [ERR_W-1:0]        s1_err_ff, s1_delta_ff;
   logic                           s1_changed_ff, s1_below_ff;
   logic [bpc_pkg::PATTERN_W-1:0]  s1_pattern_ff;
   logic [bpc_pkg::POS_W-1:0]      s1_pos_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_err_ff     <= err;
         s1_delta_ff   <= speed_delta_in;
         s1_changed_ff <= changed;
         s1_below_ff   <= below;
         s1_pattern_ff <= bpc_pkg::PHASE_TABLE[drive_idx];
         s1_pos_ff     <= pos;
      end
   end

   // ---------------- stage 2: gain products ----------------
   logic signed [16:0]             p_gain_s;
   logic signed [20:0]             d_gain_s;
   logic signed [PP_W-1:0]         prod_p_in, s2_prod_p_ff;
   logic signed [PD_W-1:0]         prod_d_in, s2_prod_d_ff;
   logic                           s2_changed_ff, s2_below_ff;
   logic [bpc_pkg::PATTERN_W-1:0]  s2_pattern_ff;
   logic [bpc_pkg::POS_W-1:0]      s2_pos_ff;

   assign p_gain_s  = $signed({1'b0, p_gain_ff});
   assign d_gain_s  = $signed({1'b0, d_gain_ff});
   assign prod_p_in = PP_W'(p_gain_s) * PP_W'(s1_err_ff);
   assign prod_d_in = PD_W'(d_gain_s) * PD_W'(s1_delta_ff);

   always_ff @(posedge clock) begin
      if (s1_vld_ff && adv2) begin
         s2_prod_p_ff  <= prod_p_in;
         s2_prod_d_ff  <= prod_d_in;
         s2_changed_ff <= s1_changed_ff;
         s2_below_ff   <= s1_below_ff;
         s2_pattern_ff <= s1_pattern_ff;
         s2_pos_ff     <= s1_pos_ff;
      end
   end

   // ---------------- stage 3: duty, commutation, held drive ----------------
   logic signed [DEM_W-1:0]        demand;
   logic [bpc_pkg::DUTY_W-1:0]     duty;
   logic                           commute;
   logic [bpc_pkg::PATTERN_W-1:0]  held_pattern_ff, held_pattern_in;
   logic [bpc_pkg::DUTY_W-1:0]     held_duty_ff, held_duty_in;
   bpc_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   always_comb begin
      demand = DEM_W'(s2_prod_p_ff) - s2_prod_d_ff;
      if (demand[DEM_W-1])
         duty = bpc_pkg::DUTY_NEG;
      else if (demand > DEM_W'(bpc_pkg::DUTY_CAP))
         duty = bpc_pkg::DUTY_CAP;
      else
         duty = bpc_pkg::DUTY_W'(demand[9:0]);

      // a rotor change commutates while short of target; otherwise a high duty forces it
      commute = s2_changed_ff ? s2_below_ff : (duty > bpc_pkg::DUTY_FORCE);

      held_pattern_in = commute ? s2_pattern_ff : held_pattern_ff;
      held_duty_in    = commute ? duty : held_duty_ff;

      rsp_data_in.drive_pattern = held_pattern_in;
      rsp_data_in.duty          = held_duty_in;
      rsp_data_in.position      = s2_pos_ff;
      rsp_data_in.below_target  = s2_below_ff;
      rsp_data_in.commutated    = commute;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pattern_ff <= bpc_pkg::PHASE_TABLE[0];
         held_duty_ff    <= bpc_pkg::DUTY_FULL;
      end else if (s2_vld_ff && adv3) begin
         held_pattern_ff <= held_pattern_in;
         held_duty_ff    <= held_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && adv3) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // incremental base tracks the pass count
   a_base_tracks_pass: assert property (@(posedge clock) disable iff (reset)
      int'(base_ff) == int'(pass_count_ff) * COUNTS_PER_REV)
      else $error("position base out of step with pass count");

   // a home pass clears the edge count
   a_pass_clears_edges: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pass_evt) |=> (edge_count_ff == '0))
      else $error("edge count not cleared on home pass");

   // input side stalls only with every stage full and the output held
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && s2_vld_ff && out_vld_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // held duty is full scale from reset or a clamped demand
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (held_duty_ff <= bpc_pkg::DUTY_CAP) || (held_duty_ff == bpc_pkg::DUTY_FULL))
      else $error("held duty outside its range");
`endif

endmodule
